// ===== hdl/cbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

    // field widths fixed by the request and result formats
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 32;
    localparam int UB_W    = 10;
    localparam int CNT_W   = 23;
    localparam int SMALL_W = 8;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [LEN_W-1:0]   t_len;
    typedef logic [UB_W-1:0]    t_ub;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [SMALL_W-1:0] t_small;

    // command kinds on the result channel
    typedef enum logic [1:0] {
        KIND_CACHED = 2'd0,
        KIND_NT     = 2'd1,
        KIND_FENCE  = 2'd2
    } t_kind;

    // copy order
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    // depth of the plan queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // exact tail sizes that go out as a single non-temporal store
    localparam t_small TAIL_NT32 = 8'd32;
    localparam t_small TAIL_NT16 = 8'd16;
    localparam t_small TAIL_NT8  = 8'd8;
    localparam t_small TAIL_NT4  = 8'd4;

    typedef struct packed {
        t_addr dest_addr;
        t_addr src_addr;
        t_len  length;
    } t_req;

    typedef struct packed {
        t_kind cmd_kind;
        logic  direction;
        t_addr region_dest;
        t_addr region_src;
        t_ub   unit_bytes;
        t_cnt  unit_count;
        logic  last;
    } t_res;

    // one classified request, as the back end walks it
    typedef struct packed {
        logic   back;
        t_addr  dest;
        t_addr  src;
        t_small head;
        t_len   bulk;
        logic   blk4;
        logic   blk2;
        logic   blk1;
        t_small tail;
        logic   tail_nt;
        logic   empty;
    } t_plan;

endpackage

`default_nettype wire

// ===== hdl/cbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbs_front #(
    parameter int LENGTH_BITS = 32,
    parameter int LINE_BYTES  = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire cbs_pkg::t_req  i_req,
    output logic                busy,
    input  wire logic           i_full,
    output logic                o_push,
    output cbs_pkg::t_plan      o_plan
);

    localparam int LB = $clog2(LINE_BYTES);
    localparam int LW = (LENGTH_BITS < cbs_pkg::LEN_W) ? LENGTH_BITS : cbs_pkg::LEN_W;
    localparam logic [63:0] LEN_MASK64 = (64'd1 << LW) - 64'd1;
    localparam cbs_pkg::t_len BULK_LOW = cbs_pkg::t_len'((64'd1 << (LB + 3)) - 64'd1);

    logic             r_vld;
    logic             r_back;
    cbs_pkg::t_addr   r_d;
    cbs_pkg::t_addr   r_s;
    cbs_pkg::t_len    r_len;
    cbs_pkg::t_small  r_head_raw;

    logic             w_ld;
    cbs_pkg::t_len    n_len;
    cbs_pkg::t_addr   n_diff;
    logic             n_back;
    cbs_pkg::t_addr   n_d_end;
    cbs_pkg::t_addr   n_s_end;
    logic [LB-1:0]    n_head_up;

    cbs_pkg::t_small  w_head;
    cbs_pkg::t_len    w_rem;
    cbs_pkg::t_small  w_tail;

    // hold off new requests while a classified one cannot enter the queue
    assign busy   = r_vld && i_full;
    assign w_ld   = start && !busy;
    assign o_push = r_vld && !i_full;

    // classify direction and find the leading edge on the way in
    always_comb begin
        n_len     = i_req.length & LEN_MASK64[cbs_pkg::LEN_W-1:0];
        n_diff    = i_req.dest_addr - i_req.src_addr;
        n_back    = n_diff < cbs_pkg::t_addr'(n_len);
        n_d_end   = i_req.dest_addr + cbs_pkg::t_addr'(n_len);
        n_s_end   = i_req.src_addr + cbs_pkg::t_addr'(n_len);
        n_head_up = LB'(0) - i_req.dest_addr[LB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ld) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_back <= n_back;
            r_len  <= n_len;
            if (n_back) begin
                r_d        <= n_d_end;
                r_s        <= n_s_end;
                r_head_raw <= cbs_pkg::t_small'(n_d_end[LB-1:0]);
            end else begin
                r_d        <= i_req.dest_addr;
                r_s        <= i_req.src_addr;
                r_head_raw <= cbs_pkg::t_small'(n_head_up);
            end
        end
    end

    // split the remaining length into head, bulk, line blocks and tail
    always_comb begin
        w_head = (cbs_pkg::t_len'(r_head_raw) > r_len) ? cbs_pkg::t_small'(r_len)
                                                       : r_head_raw;
        w_rem  = r_len - cbs_pkg::t_len'(w_head);
        w_tail = cbs_pkg::t_small'(w_rem[LB-1:0]);

        o_plan.back    = r_back;
        o_plan.dest    = r_d;
        o_plan.src     = r_s;
        o_plan.head    = w_head;
        o_plan.bulk    = w_rem & ~BULK_LOW;
        o_plan.blk4    = w_rem[LB+2];
        o_plan.blk2    = w_rem[LB+1];
        o_plan.blk1    = w_rem[LB];
        o_plan.tail    = w_tail;
        o_plan.tail_nt = (w_tail == cbs_pkg::TAIL_NT32) || (w_tail == cbs_pkg::TAIL_NT16) ||
                         (w_tail == cbs_pkg::TAIL_NT8) || (w_tail == cbs_pkg::TAIL_NT4);
        o_plan.empty   = (r_len == '0);
    end

endmodule

`default_nettype wire

// ===== hdl/cbs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbs_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cbs_pkg::t_plan  i_plan,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_avail,
    output cbs_pkg::t_plan       o_plan
);

    localparam int PW = $clog2(cbs_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(cbs_pkg::QUEUE_DEPTH + 1);

    cbs_pkg::t_plan  r_mem [cbs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_cnt == CW'(cbs_pkg::QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_plan  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_avail;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(cbs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(cbs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // store the plan
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_plan;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbs_back #(
    parameter int LINE_BYTES = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_avail,
    input  wire cbs_pkg::t_plan  i_plan,
    output logic                 o_pop,
    output logic                 o_strobe,
    output cbs_pkg::t_res        o_res
);

    localparam int LB = $clog2(LINE_BYTES);
    localparam cbs_pkg::t_len SZ4 = cbs_pkg::t_len'(4 * LINE_BYTES);
    localparam cbs_pkg::t_len SZ2 = cbs_pkg::t_len'(2 * LINE_BYTES);
    localparam cbs_pkg::t_len SZ1 = cbs_pkg::t_len'(LINE_BYTES);

    typedef enum logic [2:0] {
        CMD_HEAD  = 3'd0,
        CMD_BULK  = 3'd1,
        CMD_BLK4  = 3'd2,
        CMD_BLK2  = 3'd3,
        CMD_BLK1  = 3'd4,
        CMD_TAIL  = 3'd5,
        CMD_FENCE = 3'd6
    } t_cmd;

    cbs_pkg::t_plan  r_cur;
    cbs_pkg::t_addr  r_d;
    cbs_pkg::t_addr  r_s;
    logic [6:0]      r_pend;

    t_cmd            w_sel;
    logic            w_fire;
    logic [6:0]      w_pend_after;
    logic            w_last;
    cbs_pkg::t_len   w_size;
    cbs_pkg::t_kind  w_kind;
    cbs_pkg::t_ub    w_ub;
    cbs_pkg::t_cnt   w_cnt;
    cbs_pkg::t_addr  n_d;
    cbs_pkg::t_addr  n_s;
    logic [6:0]      w_load_pend;

    // pick the next command in issue order
    always_comb begin
        if (r_pend[CMD_HEAD]) begin
            w_sel = CMD_HEAD;
        end else if (r_pend[CMD_BULK]) begin
            w_sel = CMD_BULK;
        end else if (r_pend[CMD_BLK4]) begin
            w_sel = CMD_BLK4;
        end else if (r_pend[CMD_BLK2]) begin
            w_sel = CMD_BLK2;
        end else if (r_pend[CMD_BLK1]) begin
            w_sel = CMD_BLK1;
        end else if (r_pend[CMD_TAIL]) begin
            w_sel = CMD_TAIL;
        end else begin
            w_sel = CMD_FENCE;
        end
        w_fire              = (r_pend != '0);
        w_pend_after        = r_pend;
        w_pend_after[w_sel] = 1'b0;
        w_last              = (w_pend_after == '0);
    end

    // size and shape of the selected command
    always_comb begin
        w_kind = cbs_pkg::KIND_NT;
        w_size = '0;
        w_ub   = '0;
        w_cnt  = cbs_pkg::t_cnt'(1);
        unique case (w_sel)
            CMD_HEAD: begin
                w_kind = cbs_pkg::KIND_CACHED;
                w_size = cbs_pkg::t_len'(r_cur.head);
                w_ub   = cbs_pkg::t_ub'(r_cur.head);
            end
            CMD_BULK: begin
                w_size = r_cur.bulk;
                w_ub   = cbs_pkg::t_ub'(8 * LINE_BYTES);
                w_cnt  = cbs_pkg::t_cnt'(r_cur.bulk >> (LB + 3));
            end
            CMD_BLK4: begin
                w_size = SZ4;
                w_ub   = cbs_pkg::t_ub'(4 * LINE_BYTES);
            end
            CMD_BLK2: begin
                w_size = SZ2;
                w_ub   = cbs_pkg::t_ub'(2 * LINE_BYTES);
            end
            CMD_BLK1: begin
                w_size = SZ1;
                w_ub   = cbs_pkg::t_ub'(LINE_BYTES);
            end
            CMD_TAIL: begin
                w_kind = r_cur.tail_nt ? cbs_pkg::KIND_NT : cbs_pkg::KIND_CACHED;
                w_size = cbs_pkg::t_len'(r_cur.tail);
                w_ub   = cbs_pkg::t_ub'(r_cur.tail);
            end
            CMD_FENCE: begin
                w_kind = cbs_pkg::KIND_FENCE;
                w_cnt  = '0;
            end
            default: begin
                w_kind = cbs_pkg::KIND_FENCE;
                w_cnt  = '0;
            end
        endcase
        // move the cursor: forward it advances after, backward it retreats first
        if (r_cur.back) begin
            n_d = r_d - cbs_pkg::t_addr'(w_size);
            n_s = r_s - cbs_pkg::t_addr'(w_size);
        end else begin
            n_d = r_d + cbs_pkg::t_addr'(w_size);
            n_s = r_s + cbs_pkg::t_addr'(w_size);
        end
    end

    // take the next plan as the current one drains
    assign o_pop = i_avail && (!w_fire || w_last);

    always_comb begin
        w_load_pend            = '0;
        w_load_pend[CMD_HEAD]  = (i_plan.head != '0);
        w_load_pend[CMD_BULK]  = (i_plan.bulk != '0);
        w_load_pend[CMD_BLK4]  = i_plan.blk4;
        w_load_pend[CMD_BLK2]  = i_plan.blk2;
        w_load_pend[CMD_BLK1]  = i_plan.blk1;
        w_load_pend[CMD_TAIL]  = (i_plan.tail != '0);
        w_load_pend[CMD_FENCE] = i_plan.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_fire;
            if (o_pop) begin
                r_pend <= w_load_pend;
            end else if (w_fire) begin
                r_pend <= w_pend_after;
            end
        end
    end

    // hold plan and cursor, register the result beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_plan;
            r_d   <= i_plan.dest;
            r_s   <= i_plan.src;
        end else if (w_fire) begin
            r_d <= n_d;
            r_s <= n_s;
        end
        o_res.cmd_kind    <= w_kind;
        o_res.direction   <= (w_sel == CMD_FENCE) ? cbs_pkg::DIR_UP
                           : (r_cur.back ? cbs_pkg::DIR_DOWN : cbs_pkg::DIR_UP);
        o_res.region_dest <= r_cur.back ? n_d : r_d;
        o_res.region_src  <= r_cur.back ? n_s : r_s;
        o_res.unit_bytes  <= w_ub;
        o_res.unit_count  <= w_cnt;
        o_res.last        <= w_last;
    end

endmodule

`default_nettype wire

// ===== hdl/copy_burst_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Copy burst splitter: turns one copy request into its ordered store commands.
// Request channel: drive i_req and raise start; the request is taken at a clock
// edge where start is high and busy is low. busy rises only when the plan
// queue is full and a classified request is still waiting to enter it.
// Result channel: each command is shown on o_res for one cycle with o_strobe
// high; the receiver takes every beat and cannot stall the block.
// A request gives one to six commands (a fence-only beat when the length is
// zero); the final beat of a request carries last.
// The first beat of a request passes the front stage, the plan queue and the
// back end's pending set before o_res registers it, when the back end is free.
// Throughput: the back end issues one command per cycle with its address
// adder, so requests follow one another without gaps; up to one request is
// classified and two are queued while earlier ones issue.
// Reset (synchronous, active low) empties the front stage and the queue,
// drops any command not yet issued and clears o_strobe.
module copy_burst_splitter #(
    parameter int LENGTH_BITS = 32,
    parameter int LINE_BYTES  = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire cbs_pkg::t_req  i_req,
    output logic                busy,
    output logic                o_strobe,
    output cbs_pkg::t_res       o_res
);

    logic            w_push;
    logic            w_full;
    cbs_pkg::t_plan  w_plan_in;
    cbs_pkg::t_plan  w_plan_out;
    logic            w_avail;
    logic            w_pop;

    // classify requests
    cbs_front #(
        .LENGTH_BITS (LENGTH_BITS),
        .LINE_BYTES  (LINE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_plan  (w_plan_in)
    );

    // decouple front and back
    cbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_plan  (w_plan_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_plan  (w_plan_out)
    );

    // issue commands
    cbs_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_avail),
        .i_plan   (w_plan_out),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE      = 64;
    localparam int BULK      = 8 * LINE;
    localparam int MODE_ANY  = 0;
    localparam int MODE_FWD  = 1;
    localparam int MODE_BACK = 2;

    logic            i_clk;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    cbs_pkg::t_req   i_req   = '0;
    logic            busy;
    logic            o_strobe;
    cbs_pkg::t_res   o_res;

    cbs_pkg::t_res   exp_cmds [$];
    int              err_count  = 0;
    int              beat_count = 0;
    int              idle_pct   = 0;

    copy_burst_splitter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("beat %0d: %s mismatch, got %0h expected %0h",
                 beat_count, what, got, want);
        err_count++;
    endtask

    // Work out the store commands for one copy request and queue them
    function automatic void plan_copy(input cbs_pkg::t_req r);
        cbs_pkg::t_addr  d, s;
        logic [63:0]     left, head, nblk, span;
        logic            dn;
        cbs_pkg::t_kind  kinds [6];
        logic [63:0]     ubs [6];
        logic [63:0]     cnts [6];
        int              n;
        cbs_pkg::t_res   cmd;
        n    = 0;
        left = {32'b0, r.length};
        dn   = (r.dest_addr - r.src_addr) < left;
        // head alignment to a line boundary
        if (dn) begin
            d    = r.dest_addr + left;
            s    = r.src_addr + left;
            head = {58'b0, d[5:0]};
        end else begin
            d    = r.dest_addr;
            s    = r.src_addr;
            head = {58'b0, d[5:0]};
            if (head != 0) head = 64'(LINE) - head;
        end
        if (head > left) head = left;
        if (head != 0) begin
            kinds[n] = cbs_pkg::KIND_CACHED; ubs[n] = head; cnts[n] = 64'd1; n++;
            left -= head;
        end
        // bulk run, then single 4, 2 and 1-line blocks
        nblk = left / 64'(BULK);
        if (nblk != 0) begin
            kinds[n] = cbs_pkg::KIND_NT; ubs[n] = 64'(BULK); cnts[n] = nblk; n++;
            left -= nblk * 64'(BULK);
        end
        if (left >= 64'(4 * LINE)) begin
            kinds[n] = cbs_pkg::KIND_NT; ubs[n] = 64'(4 * LINE); cnts[n] = 64'd1; n++;
            left -= 64'(4 * LINE);
        end
        if (left >= 64'(2 * LINE)) begin
            kinds[n] = cbs_pkg::KIND_NT; ubs[n] = 64'(2 * LINE); cnts[n] = 64'd1; n++;
            left -= 64'(2 * LINE);
        end
        if (left >= 64'(LINE)) begin
            kinds[n] = cbs_pkg::KIND_NT; ubs[n] = 64'(LINE); cnts[n] = 64'd1; n++;
            left -= 64'(LINE);
        end
        // tail: exact 32, 16, 8 and 4-byte sizes go non-temporal
        if (left == 64'd32 || left == 64'd16 || left == 64'd8 || left == 64'd4) begin
            kinds[n] = cbs_pkg::KIND_NT; ubs[n] = left; cnts[n] = 64'd1; n++;
        end else if (left != 0) begin
            kinds[n] = cbs_pkg::KIND_CACHED; ubs[n] = left; cnts[n] = 64'd1; n++;
        end
        // walk the commands, retreating first when copying downwards
        for (int i = 0; i < n; i++) begin
            span = ubs[i] * cnts[i];
            if (dn) begin
                d -= span;
                s -= span;
            end
            cmd.cmd_kind    = kinds[i];
            cmd.direction   = dn ? cbs_pkg::DIR_DOWN : cbs_pkg::DIR_UP;
            cmd.region_dest = d;
            cmd.region_src  = s;
            cmd.unit_bytes  = cbs_pkg::t_ub'(ubs[i]);
            cmd.unit_count  = cbs_pkg::t_cnt'(cnts[i]);
            cmd.last        = (i == n - 1);
            exp_cmds.push_back(cmd);
            if (!dn) begin
                d += span;
                s += span;
            end
        end
        // empty request: fence only
        if (n == 0) begin
            cmd.cmd_kind    = cbs_pkg::KIND_FENCE;
            cmd.direction   = cbs_pkg::DIR_UP;
            cmd.region_dest = r.dest_addr;
            cmd.region_src  = r.src_addr;
            cmd.unit_bytes  = '0;
            cmd.unit_count  = '0;
            cmd.last        = 1'b1;
            exp_cmds.push_back(cmd);
        end
    endfunction

    // Check every result beat against the oldest expectation
    always @(posedge i_clk) begin
        cbs_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            beat_count++;
            if (exp_cmds.size() == 0) begin
                report_mismatch("unexpected beat", o_res.region_dest, '0);
            end else begin
                want = exp_cmds.pop_front();
                if (o_res.cmd_kind != want.cmd_kind)
                    report_mismatch("cmd_kind", 64'(o_res.cmd_kind), 64'(want.cmd_kind));
                if (o_res.direction != want.direction)
                    report_mismatch("direction", 64'(o_res.direction),
                                    64'(want.direction));
                if (o_res.region_dest != want.region_dest)
                    report_mismatch("region_dest", o_res.region_dest, want.region_dest);
                if (o_res.region_src != want.region_src)
                    report_mismatch("region_src", o_res.region_src, want.region_src);
                if (o_res.unit_bytes != want.unit_bytes)
                    report_mismatch("unit_bytes", 64'(o_res.unit_bytes),
                                    64'(want.unit_bytes));
                if (o_res.unit_count != want.unit_count)
                    report_mismatch("unit_count", 64'(o_res.unit_count),
                                    64'(want.unit_count));
                if (o_res.last != want.last)
                    report_mismatch("last", 64'(o_res.last), 64'(want.last));
            end
        end
    end

    // Offer one request, idling first at random; predict once it is taken
    task automatic send_req(input cbs_pkg::t_addr dest, input cbs_pkg::t_addr src,
                            input cbs_pkg::t_len len);
        cbs_pkg::t_req r;
        int            gap;
        r.dest_addr = dest;
        r.src_addr  = src;
        r.length    = len;
        gap = ($urandom_range(1, 100) <= idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        plan_copy(r);
    endtask

    // Hold off until every expected beat has arrived, then let the pipe settle
    task automatic wait_drained();
        start <= 1'b0;
        while (exp_cmds.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic cbs_pkg::t_addr rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic cbs_pkg::t_len rand_len();
        cbs_pkg::t_len tail;
        case ($urandom_range(0, 5))
            0: tail = 32'd4;
            1: tail = 32'd8;
            2: tail = 32'd16;
            3: tail = 32'd32;
            4: tail = 32'd0;
            default: tail = $urandom_range(0, 63);
        endcase
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 80);
            1: return $urandom_range(0, 40) * LINE + tail;
            2: return $urandom_range(0, 5000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_edge_cases();
        cbs_pkg::t_addr top;
        top = '1;
        // empty requests give a lone fence
        send_req(64'h1000, 64'h2000, 0);
        send_req(64'h3000, 64'h3000, 0);
        // same address: copies downwards
        send_req(64'h4000, 64'h4000, 100);
        // exact non-temporal tails and cached odd tails
        send_req(64'h5000, 64'h9000, 4);
        send_req(64'h5040, 64'h9040, 8);
        send_req(64'h5080, 64'h9080, 16);
        send_req(64'h50c0, 64'h90c0, 32);
        send_req(64'h5100, 64'h9100, 3);
        send_req(64'h5140, 64'h9140, 33);
        // single blocks and bulk runs
        send_req(64'h6000, 64'ha000, 64);
        send_req(64'h6000, 64'ha000, 128);
        send_req(64'h6000, 64'ha000, 256);
        send_req(64'h6000, 64'ha000, 512);
        send_req(64'h6000, 64'ha000, 1024);
        // every command kind in one upward request; most kinds in a downward one
        send_req(64'h7001, 64'hb003, 63 + 512 + 256 + 128 + 64 + 33);
        send_req(64'h7041, 64'h7001, 31 + 512 + 256 + 128 + 64 + 17);
        // head clipped by a short length
        send_req(64'h8001, 64'hc000, 10);
        // downward copy ending in a line block and a cached 48-byte tail
        send_req(64'h8810, 64'h8800, 16 + 128 + 3);
        // address extremes and wrap-around
        send_req(top, 64'h0, 32'hffff_ffff);
        send_req(64'h0, top, 32'hffff_ffff);
        send_req(64'h1, 64'h0, 32'hffff_ffff);
        send_req(64'hffff_ffff_ffff_ffc0, 64'h0000_0000_0000_1000, 128);
        send_req(top, top, 1);
        send_req(64'h0, 64'h0, 32'h8000_0000);
        wait_drained();
    endtask

    task automatic test_random_copies(input int mode, input int count);
        cbs_pkg::t_addr src, dest;
        cbs_pkg::t_len  len;
        logic [63:0]    delta;
        for (int i = 0; i < count; i++) begin
            len = rand_len();
            src = rand_addr();
            case (mode)
                MODE_FWD: dest = rand_addr();
                MODE_BACK: begin
                    // overlapping copy, mostly destination above source
                    delta = (len == 0) ? 64'd0 : 64'($urandom_range(0, len - 1));
                    dest  = ($urandom_range(0, 3) != 0) ? src + delta : src - delta;
                end
                default: dest = ($urandom_range(0, 1) != 0)
                              ? rand_addr()
                              : src + 64'($urandom_range(0, 600));
            endcase
            send_req(dest, src, len);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 0;
        test_edge_cases();
        test_random_copies(MODE_FWD, 30);

        idle_pct = 58;
        test_random_copies(MODE_BACK, 30);
        // let the block run completely dry mid-run
        wait_drained();

        idle_pct = 0;
        test_random_copies(MODE_ANY, 35);

        idle_pct = 35;
        test_random_copies(MODE_BACK, 20);
        test_random_copies(MODE_ANY, 15);

        wait_drained();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
